### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that sleep while rst is high
`define CHECK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that also hold across reset
`define CHECK_FROM_RESET(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/fms_pkg.sv
`timescale 1ns / 1ps
package fms_pkg;

  localparam int SET_COUNT   = 7;
  localparam int CFG_COUNT   = 6;
  localparam int POINT_W     = 16;
  localparam int SET_W       = 3;
  localparam int MEMB_W      = 16;
  localparam int QUO_W       = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // 1.0 in Q1.15
  localparam logic [MEMB_W-1:0] ONE_Q15 = 16'h8000;

  typedef logic signed [POINT_W-1:0] point_t;
  typedef logic [SET_W-1:0]          set_idx_t;
  typedef logic [MEMB_W-1:0]         memb_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_NEG_A = 3'd0,
    CFG_NEG_B = 3'd1,
    CFG_NEG_C = 3'd2,
    CFG_POS_A = 3'd3,
    CFG_POS_B = 3'd4,
    CFG_POS_C = 3'd5
  } cfg_index_t;

  // Breakpoint reset values
  localparam point_t RESET_NEG_A = -16'sd768;
  localparam point_t RESET_NEG_B = -16'sd512;
  localparam point_t RESET_NEG_C = -16'sd256;
  localparam point_t RESET_POS_A = 16'sd256;
  localparam point_t RESET_POS_B = 16'sd512;
  localparam point_t RESET_POS_C = 16'sd768;

  // Sorted breakpoints after reset, zero point included
  localparam point_t SORTED_RESET [SET_COUNT] = '{
    -16'sd768, -16'sd512, -16'sd256, 16'sd0, 16'sd256, 16'sd512, 16'sd768
  };

  // Classified sample: set ranks plus offset into the gap and gap width
  typedef struct packed {
    set_idx_t          lower_set;
    set_idx_t          upper_set;
    logic              single_hit;
    logic [POINT_W-1:0] n;
    logic [POINT_W-1:0] d;
  } front_item_t;

  // Side data that rides along with the divider lanes
  typedef struct packed {
    set_idx_t lower_set;
    set_idx_t upper_set;
    logic     single_hit;
    logic     curve_high;
  } back_meta_t;

endpackage

### src/fuzzy_membership_seven_sets.sv
`timescale 1ns / 1ps
// Fuzzifies a signed Q8.8 sample against seven sets whose breakpoints are
// six programmable points plus a fixed zero, ranked in ascending order.
// s_axis carries one sample per transaction in tdata[15:0]. m_axis returns
// one result per sample in order: tdata holds the set ranks and the linear
// and S-curve memberships (Q1.15), tuser flags a single-set hit.
// The cfg port writes a breakpoint at any edge with cfg_we high; the sorted
// copy of the points follows in the next cycle, so writes go in while idle.
// Throughput is one sample per cycle while the receiver does not stall. A sample
// passes the input register, which loads on the accepting edge, the compare
// stage, the queue, operand select, the squarers, sixteen stages in each of
// the two parallel dividers (linear and S-curve ratio), and the output
// register, which drives m_axis_tvalid.
// Reset loads the default breakpoints and empties every stage and the queue.
// When the receiver stalls, the result holds in the output register and the
// back pipeline freezes; the front keeps taking samples into a four-entry
// queue and drops s_axis_tready only when the queue and front stages fill.
`include "assert_macros.svh"
module fuzzy_membership_seven_sets (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] lower_set, [5:3] upper_set, [21:6] linear_lower, [37:22] linear_upper,
  // [53:38] curve_lower, [69:54] curve_upper, [71:70] zero
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tuser   // [0] single_hit
);
  import fms_pkg::*;

  front_item_t f_item, q_head;
  logic        f_push, q_full, q_empty, b_pop;
  set_idx_t    out_lower, out_upper;
  logic        out_single;
  memb_t       out_lin_lo, out_lin_hi, out_cur_lo, out_cur_hi;
  logic        single_ok, pair_ok, idle_open;

  fms_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (s_axis_tdata),
    .q_full    (q_full),
    .push      (f_push),
    .item      (f_item)
  );

  fms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_item (f_item),
    .pop       (b_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  fms_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .empty        (q_empty),
    .pop          (b_pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .lower_set    (out_lower),
    .upper_set    (out_upper),
    .single_hit   (out_single),
    .linear_lower (out_lin_lo),
    .linear_upper (out_lin_hi),
    .curve_lower  (out_cur_lo),
    .curve_upper  (out_cur_hi)
  );

  // Result packing
  assign m_axis_tdata = {2'b00, out_cur_hi, out_cur_lo, out_lin_hi, out_lin_lo,
                         out_upper, out_lower};
  assign m_axis_tuser = out_single;

  // Terms for the checks below
  assign single_ok = !out_single ||
                     (out_lower == out_upper && out_lin_lo == ONE_Q15 &&
                      out_lin_hi == ONE_Q15 && out_cur_lo == ONE_Q15 &&
                      out_cur_hi == ONE_Q15);
  assign pair_ok   = out_single ||
                     (out_upper == out_lower + 3'd1 &&
                      17'(out_lin_lo) + 17'(out_lin_hi) == 17'(ONE_Q15) &&
                      17'(out_cur_lo) + 17'(out_cur_hi) == 17'(ONE_Q15));
  assign idle_open = !m_axis_tvalid && s_axis_tready;

  // A single hit reports one set at full membership everywhere
  `CHECK_ALWAYS(a_single_full, m_axis_tvalid |-> single_ok, "single hit with partial membership")

  // A pair names neighboring sets and both memberships sum to one
  `CHECK_ALWAYS(a_pair_sum, m_axis_tvalid |-> pair_ok, "membership pair inconsistent")

  // Right after reset nothing is pending and input is open
  `CHECK_FROM_RESET(a_reset_clear, $past(rst) |-> idle_open, "pipeline not empty after reset")

endmodule

### src/fms_front.sv
`timescale 1ns / 1ps
module fms_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [15:0]              in_sample,
  input  logic                     q_full,
  output logic                     push,
  output fms_pkg::front_item_t     item
);
  import fms_pkg::*;

  point_t neg_point_a, neg_point_b, neg_point_c;
  point_t pos_point_a, pos_point_b, pos_point_c;
  point_t pts [SET_COUNT];
  set_idx_t rank [SET_COUNT];
  point_t sorted [SET_COUNT];
  point_t sorted_next [SET_COUNT];

  logic   s1_valid;
  point_t s1_sample;
  logic   s2_valid;
  point_t s2_sample;
  set_idx_t s2_cnt;
  logic   s2_eq;

  logic   en1, en2;
  logic [SET_COUNT-1:0] lt, eq;
  set_idx_t cnt;
  set_idx_t lo_idx, hi_idx;
  logic signed [POINT_W:0] n_wide, d_wide;

  // Breakpoint registers
  always_ff @(posedge clk) begin
    if (rst) begin
      neg_point_a <= RESET_NEG_A;
      neg_point_b <= RESET_NEG_B;
      neg_point_c <= RESET_NEG_C;
      pos_point_a <= RESET_POS_A;
      pos_point_b <= RESET_POS_B;
      pos_point_c <= RESET_POS_C;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NEG_A: neg_point_a <= cfg_data;
        CFG_NEG_B: neg_point_b <= cfg_data;
        CFG_NEG_C: neg_point_c <= cfg_data;
        CFG_POS_A: pos_point_a <= cfg_data;
        CFG_POS_B: pos_point_b <= cfg_data;
        CFG_POS_C: pos_point_c <= cfg_data;
        default: ;
      endcase
    end
  end

  // Rank sort of the seven points; ties keep list order
  always_comb begin
    pts[0] = neg_point_a;
    pts[1] = neg_point_b;
    pts[2] = neg_point_c;
    pts[3] = pos_point_a;
    pts[4] = pos_point_b;
    pts[5] = pos_point_c;
    pts[6] = '0;
    for (int i = 0; i < SET_COUNT; i++) begin
      rank[i] = '0;
      for (int j = 0; j < SET_COUNT; j++) begin
        if (pts[j] < pts[i] || (j < i && pts[j] == pts[i])) begin
          rank[i] = rank[i] + 3'd1;
        end
      end
    end
    for (int r = 0; r < SET_COUNT; r++) begin
      sorted_next[r] = pts[0];
      for (int i = 0; i < SET_COUNT; i++) begin
        if (rank[i] == SET_W'(r)) begin
          sorted_next[r] = pts[i];
        end
      end
    end
  end

  // Sorted copy, registered from the breakpoints; it follows a write in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      sorted <= SORTED_RESET;
    end else begin
      sorted <= sorted_next;
    end
  end

  // Stall chain: input register, compare stage, then queue
  assign en2      = !s2_valid || !q_full;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;
  assign push     = s2_valid && !q_full;

  // Compare sample against every sorted point
  always_comb begin
    cnt = '0;
    for (int i = 0; i < SET_COUNT; i++) begin
      lt[i] = sorted[i] < s1_sample;
      eq[i] = sorted[i] == s1_sample;
      cnt   = cnt + SET_W'(lt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= in_valid;
      if (en2) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) s1_sample <= in_sample;
    if (en2) begin
      s2_sample <= s1_sample;
      s2_cnt    <= cnt;
      s2_eq     <= |eq;
    end
  end

  // Classify: single hit or the gap between two neighbors
  always_comb begin
    hi_idx = (s2_cnt == SET_W'(SET_COUNT)) ? SET_W'(SET_COUNT - 1) : s2_cnt;
    lo_idx = (s2_cnt == '0) ? '0 : s2_cnt - 3'd1;
    n_wide = {s2_sample[POINT_W-1], s2_sample} - {sorted[lo_idx][POINT_W-1], sorted[lo_idx]};
    d_wide = {sorted[hi_idx][POINT_W-1], sorted[hi_idx]}
           - {sorted[lo_idx][POINT_W-1], sorted[lo_idx]};
    item.n = n_wide[POINT_W-1:0];
    item.d = d_wide[POINT_W-1:0];
    priority if (s2_eq) begin
      item.lower_set  = s2_cnt;
      item.upper_set  = s2_cnt;
      item.single_hit = 1'b1;
    end else if (s2_cnt == SET_W'(SET_COUNT) || s2_cnt == '0) begin
      item.lower_set  = hi_idx;
      item.upper_set  = hi_idx;
      item.single_hit = 1'b1;
    end else begin
      item.lower_set  = lo_idx;
      item.upper_set  = s2_cnt;
      item.single_hit = 1'b0;
    end
  end

endmodule

### src/fms_queue.sv
`timescale 1ns / 1ps
module fms_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  fms_pkg::front_item_t push_item,
  input  logic                 pop,
  output fms_pkg::front_item_t head,
  output logic                 full,
  output logic                 empty
);
  import fms_pkg::*;

  front_item_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [QPTR_W:0]      count;
  logic                 do_push, do_pop;

  assign full    = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

endmodule

### src/fms_div.sv
`timescale 1ns / 1ps
module fms_div #(
  parameter int DEN_W = 17,
  parameter int QUO_W = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [DEN_W+QUO_W-1:0]   num,
  input  logic [DEN_W-1:0]         den,
  output logic [QUO_W-1:0]         quo
);

  // Per-stage state: partial remainder, unused numerator bits, divisor, quotient
  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [DEN_W-1:0] rem_in, den_in;
    logic [QUO_W-1:0] low_in, quo_in;
    logic [DEN_W:0]   trial, diff;
    logic             ge;

    // Previous stage or the operands
    if (s == 0) begin : g_first
      assign rem_in = num[DEN_W+QUO_W-1:QUO_W];
      assign low_in = num[QUO_W-1:0];
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    // One restoring step
    assign trial = {rem_in, low_in[QUO_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low_q[s] <= {low_in[QUO_W-2:0], 1'b0};
        den_q[s] <= den_in;
        quo_q[s] <= {quo_in[QUO_W-2:0], ge};
      end
    end
  end

  assign quo = quo_q[QUO_W-1];

endmodule

### src/fms_back.sv
`timescale 1ns / 1ps
module fms_back (
  input  logic                 clk,
  input  logic                 rst,
  input  fms_pkg::front_item_t head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fms_pkg::set_idx_t    lower_set,
  output fms_pkg::set_idx_t    upper_set,
  output logic                 single_hit,
  output fms_pkg::memb_t       linear_lower,
  output fms_pkg::memb_t       linear_upper,
  output fms_pkg::memb_t       curve_lower,
  output fms_pkg::memb_t       curve_upper
);
  import fms_pkg::*;

  localparam int LIN_DEN_W = POINT_W + 1;
  localparam int CUR_DEN_W = 2 * POINT_W + 1;

  logic                 advance;

  logic                 pre_valid;
  front_item_t          pre_item;
  logic [POINT_W-1:0]   pre_m;
  logic                 pre_high;
  logic                 head_high;
  logic [POINT_W-1:0]   head_m;

  logic                 mul_valid;
  front_item_t          mul_item;
  logic                 mul_high;
  logic [2*POINT_W-1:0] mul_mm, mul_dd;

  logic [LIN_DEN_W+QUO_W-1:0] lin_num;
  logic [LIN_DEN_W-1:0]       lin_den;
  logic [CUR_DEN_W+QUO_W-1:0] cur_num;
  logic [CUR_DEN_W-1:0]       cur_den;
  logic [QUO_W-1:0]           lin_quo, cur_quo;

  logic                 meta_valid [QUO_W];
  back_meta_t           meta [QUO_W];
  back_meta_t           fin;

  // Whole back pipeline moves unless the output register is held
  assign advance = !out_valid || out_ready;
  assign pop     = advance && !empty;

  // Curve half: from the midpoint on when 2n >= d
  assign head_high = {head.n, 1'b0} >= {1'b0, head.d};
  assign head_m    = head_high ? head.d - head.n : head.n;

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid <= 1'b0;
      mul_valid <= 1'b0;
      for (int s = 0; s < QUO_W; s++) meta_valid[s] <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      pre_valid     <= !empty;
      mul_valid     <= pre_valid;
      meta_valid[0] <= mul_valid;
      for (int s = 1; s < QUO_W; s++) meta_valid[s] <= meta_valid[s-1];
      out_valid     <= meta_valid[QUO_W-1];
    end
  end

  // Operand select and squaring
  always_ff @(posedge clk) begin
    if (advance) begin
      pre_item <= head;
      pre_m    <= head_m;
      pre_high <= head_high;
      mul_item <= pre_item;
      mul_high <= pre_high;
      mul_mm   <= pre_m * pre_m;
      mul_dd   <= pre_item.d * pre_item.d;
    end
  end

  // Rounded ratios: (2*num + den) / (2*den)
  assign lin_num = {1'b0, mul_item.n, QUO_W'(0)} + (LIN_DEN_W + QUO_W)'(mul_item.d);
  assign lin_den = {mul_item.d, 1'b0};
  assign cur_num = {mul_mm, 17'h0} + (CUR_DEN_W + QUO_W)'(mul_dd);
  assign cur_den = {mul_dd, 1'b0};

  fms_div #(.DEN_W(LIN_DEN_W), .QUO_W(QUO_W)) u_lin_div (
    .clk (clk),
    .en  (advance),
    .num (lin_num),
    .den (lin_den),
    .quo (lin_quo)
  );

  fms_div #(.DEN_W(CUR_DEN_W), .QUO_W(QUO_W)) u_cur_div (
    .clk (clk),
    .en  (advance),
    .num (cur_num),
    .den (cur_den),
    .quo (cur_quo)
  );

  // Side data delay matched to the divider lanes
  always_ff @(posedge clk) begin
    if (advance) begin
      meta[0] <= '{lower_set:  mul_item.lower_set,
                   upper_set:  mul_item.upper_set,
                   single_hit: mul_item.single_hit,
                   curve_high: mul_high};
      for (int s = 1; s < QUO_W; s++) meta[s] <= meta[s-1];
    end
  end

  assign fin = meta[QUO_W-1];

  // Output register: complementary pairs, or 1.0 on a single hit
  always_ff @(posedge clk) begin
    if (advance) begin
      lower_set  <= fin.lower_set;
      upper_set  <= fin.upper_set;
      single_hit <= fin.single_hit;
      if (fin.single_hit) begin
        linear_lower <= ONE_Q15;
        linear_upper <= ONE_Q15;
        curve_lower  <= ONE_Q15;
        curve_upper  <= ONE_Q15;
      end else begin
        linear_lower <= ONE_Q15 - lin_quo;
        linear_upper <= lin_quo;
        if (fin.curve_high) begin
          curve_lower <= cur_quo;
          curve_upper <= ONE_Q15 - cur_quo;
        end else begin
          curve_lower <= ONE_Q15 - cur_quo;
          curve_upper <= cur_quo;
        end
      end
    end
  end

endmodule
